FILE: src/levenshtein_edit_distance_unit_macros.svh
// assertion macros for the edit distance unit checker
`ifndef LEVENSHTEIN_EDIT_DISTANCE_UNIT_MACROS_SVH
`define LEVENSHTEIN_EDIT_DISTANCE_UNIT_MACROS_SVH

// property must hold at every clock outside reset
`define CHK_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define CHK_NEVER(lbl, cond, msg) \
    `CHK_PROP(lbl, !(cond), msg)

`endif

FILE: src/led_pkg.sv
`default_nettype none

package led_pkg;

    typedef enum logic [1:0] {
        CMD_TARGET = 2'd0,
        CMD_SOURCE = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_OVERFLOW = 2'd1,
        STATUS_ORDER    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_tgt;
        logic flag_order;
        logic flag_ovf;
        logic start_src;
        logic step;
        logic bump_src;
        logic fin_rd;
        logic emit_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic tl_zero;
        logic tl_full;
        logic sl_nonzero;
        logic sl_full;
        logic last_j;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: src/levenshtein_edit_distance_unit.sv
// target symbol: written to memory; finish: read, then ST_FIN until the output register is free
// source symbol: scans the target in ST_SCAN, one row entry per cycle through the row memory
// finish result registered out of ST_FIN, held while downstream stalls
// a new item is taken while a result waits; a second finish waits for the output register
// reset (rst_n, async, active low) empties both strings and flags, no memory clearing pass
`default_nettype none

module levenshtein_edit_distance_unit
    import led_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // symbol
    input  wire logic [1:0] s_tuser,   // command
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // distance, zero pad
    output logic [1:0]      m_tuser    // status
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    led_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    led_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .symbol   (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: src/led_ctrl.sv
`default_nettype none

module led_ctrl
    import led_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic [1:0] s_tuser,
    input  wire dp_stat_t  stat,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (cmd_t'(s_tuser))
                        CMD_TARGET:
                        begin
                            priority if (stat.sl_nonzero)
                                cmd.flag_order = 1'b1;
                            else if (stat.tl_full)
                                cmd.flag_ovf = 1'b1;
                            else
                                cmd.load_tgt = 1'b1;
                        end
                        CMD_SOURCE:
                        begin
                            priority if (stat.sl_full)
                                cmd.flag_ovf = 1'b1;
                            else if (stat.tl_zero)
                                cmd.bump_src = 1'b1;
                            else
                            begin
                                cmd.start_src = 1'b1;
                                state_next    = ST_SCAN;
                            end
                        end
                        CMD_FINISH:
                        begin
                            cmd.fin_rd = 1'b1;
                            state_next = ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.last_j)
                begin
                    cmd.bump_src = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/led_dp.sv
`default_nettype none

module led_dp
    import led_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_cmd_t  cmd,
    output dp_stat_t        stat,
    input  wire logic [7:0] symbol,
    input  wire logic       m_tready,
    output logic            m_tvalid,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WW = CW + 8;

    logic [7:0]    tgt_mem [MAX_LEN];
    logic [CW-1:0] row_mem [MAX_LEN];

    logic [CW-1:0] tl_reg, tl_next;
    logic [CW-1:0] sl_reg, sl_next;
    logic          ovf_reg, ovf_next;
    logic          ord_reg, ord_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] diag_reg, diag_next;
    logic [CW-1:0] left_reg, left_next;
    logic [7:0]    sym_reg, sym_next;
    logic [6:0]    dist_reg, dist_next;
    logic [1:0]    stat_reg, stat_next;

    logic [7:0]    tgt_rd_reg;
    logic [CW-1:0] row_rd_reg;

    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [CW-1:0] jm1;
    logic [CW-1:0] tl_m1;
    logic [CW-1:0] above;
    logic [CW:0]   up_w, lf_w, dg_w, best_w;
    logic [CW-1:0] best;
    logic [CW-1:0] fin_d;
    logic [WW-1:0] fin_w;
    logic [6:0]    dist_sat;
    logic          last_j;

    assign last_j = (j_reg == tl_reg);
    assign jm1    = j_reg - CW'(1);
    assign tl_m1  = tl_reg - CW'(1);

    assign stat.tl_zero    = (tl_reg == '0);
    assign stat.tl_full    = (tl_reg == CW'(MAX_LEN));
    assign stat.sl_nonzero = (sl_reg != '0);
    assign stat.sl_full    = (sl_reg == CW'(MAX_LEN));
    assign stat.last_j     = last_j;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, dist_reg};
    assign m_tuser  = stat_reg;

    // read address shared by both memories
    always_comb
    begin
        priority if (cmd.start_src)
            rd_addr = '0;
        else if (cmd.fin_rd)
            rd_addr = tl_m1[AW-1:0];
        else
            rd_addr = j_reg[AW-1:0];
    end

    assign rd_en = cmd.start_src || cmd.fin_rd || (cmd.step && !last_j);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            tgt_rd_reg <= tgt_mem[rd_addr];
            row_rd_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tgt)
        begin
            tgt_mem[tl_reg[AW-1:0]] <= symbol;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            row_mem[jm1[AW-1:0]] <= best;
        end
    end

    // row entries are only valid once a source symbol has gone through
    assign above = (sl_reg == '0) ? j_reg : row_rd_reg;
    assign up_w  = {1'b0, above} + (CW+1)'(1);
    assign lf_w  = {1'b0, left_reg} + (CW+1)'(1);
    assign dg_w  = {1'b0, diag_reg} + (CW+1)'(tgt_rd_reg != sym_reg);

    always_comb
    begin
        best_w = up_w;
        if (lf_w < best_w)
            best_w = lf_w;
        if (dg_w < best_w)
            best_w = dg_w;
    end

    assign best = best_w[CW-1:0];

    always_comb
    begin
        priority if (tl_reg == '0)
            fin_d = sl_reg;
        else if (sl_reg == '0)
            fin_d = tl_reg;
        else
            fin_d = row_rd_reg;
    end

    assign fin_w    = WW'(fin_d);
    assign dist_sat = (fin_w > WW'(127)) ? 7'd127 : fin_w[6:0];

    always_comb
    begin
        tl_next        = tl_reg;
        sl_next        = sl_reg;
        ovf_next       = ovf_reg;
        ord_next       = ord_reg;
        out_valid_next = out_valid_reg && !m_tready;
        j_next         = j_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        sym_next       = sym_reg;
        dist_next      = dist_reg;
        stat_next      = stat_reg;

        if (cmd.load_tgt)
            tl_next = tl_reg + CW'(1);
        if (cmd.flag_order)
            ord_next = 1'b1;
        if (cmd.flag_ovf)
            ovf_next = 1'b1;
        if (cmd.start_src)
        begin
            sym_next  = symbol;
            j_next    = CW'(1);
            diag_next = sl_reg;
            left_next = sl_reg + CW'(1);
        end
        if (cmd.step)
        begin
            j_next    = j_reg + CW'(1);
            diag_next = above;
            left_next = best;
        end
        if (cmd.bump_src)
            sl_next = sl_reg + CW'(1);
        if (cmd.emit_clear)
        begin
            dist_next      = dist_sat;
            priority if (ovf_reg)
                stat_next = STATUS_OVERFLOW;
            else if (ord_reg)
                stat_next = STATUS_ORDER;
            else
                stat_next = STATUS_OK;
            out_valid_next = 1'b1;
            tl_next        = '0;
            sl_next        = '0;
            ovf_next       = 1'b0;
            ord_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg        <= '0;
            sl_reg        <= '0;
            ovf_reg       <= 1'b0;
            ord_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tl_reg        <= tl_next;
            sl_reg        <= sl_next;
            ovf_reg       <= ovf_next;
            ord_reg       <= ord_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        sym_reg  <= sym_next;
        dist_reg <= dist_next;
        stat_reg <= stat_next;
    end

endmodule

`default_nettype wire

FILE: src/led_checker.sv
`default_nettype none

`include "levenshtein_edit_distance_unit_macros.svh"

module led_checker
    import led_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [1:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [1:0] m_tuser
);

    logic fin_acc;

    assign fin_acc = s_tvalid && s_tready && (s_tuser == CMD_FINISH);

    `CHK_PROP(a_out_hold, (m_tvalid && !m_tready |=> m_tvalid), "result dropped while stalled")
    `CHK_PROP(a_out_stable, (m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")
    `CHK_PROP(a_rise_after_fin, ($rose(m_tvalid) |-> $past(fin_acc, 2)), "result without finish")
    `CHK_NEVER(a_status_code, m_tvalid && (m_tuser == 2'd3), "bad status code")

endmodule

bind levenshtein_edit_distance_unit led_checker u_led_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
